FILE: hdl/glcc_pkg.sv
// Shared types and constants for the grid line collision checker.
// Used by the front end, queue, back end and top level; depends on nothing.
`default_nettype none

package glcc_pkg;

  // Default map side, in cells
  localparam int MAX_SIDE_DEF = 256;

  // Field widths fixed by the item format
  localparam int COORD_W = 10;
  localparam int IDX_W   = 16;
  localparam int VAL_W   = 8;
  localparam int CNT_W   = 11;
  localparam int DIM_W   = 9;
  localparam int STAT_W  = 2;
  localparam int ERR_W   = 12;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_FREE = 2'd0,
    ST_OOB  = 2'd1,
    ST_HIT  = 2'd2
  } status_t;

  // One classified command, as queued for the back end
  typedef struct packed {
    logic                      is_query;
    logic [IDX_W-1:0]          cell_index;
    logic                      in_range;
    logic                      cell_busy;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      xs_neg;
    logic                      ys_neg;
    logic [ERR_W-1:0]          dx2;
    logic [ERR_W-1:0]          dy2;
    logic signed [ERR_W-1:0]   err;
    logic [CNT_W-1:0]          n;
  } op_entry_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Effective map dimensions, already clamped
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

endpackage

`default_nettype wire

FILE: hdl/glcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`default_nettype none

module glcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/glcc_front.sv
// Front end: accepts command transfers and classifies them into queue entries.
// Uses glcc_pkg for field widths, opcodes and the entry type.
`default_nettype none

module glcc_front #(
  parameter int MAX_SIDE = glcc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                opcode,
  input  wire logic        [glcc_pkg::IDX_W-1:0]   cell_index,
  input  wire logic signed [glcc_pkg::VAL_W-1:0]   cell_value,
  input  wire logic signed [glcc_pkg::COORD_W-1:0] start_x,
  input  wire logic signed [glcc_pkg::COORD_W-1:0] start_y,
  input  wire logic signed [glcc_pkg::COORD_W-1:0] end_x,
  input  wire logic signed [glcc_pkg::COORD_W-1:0] end_y,
  input  wire glcc_pkg::q_status_t                 q_stat,
  input  wire logic                                clearing,
  output logic                                     push,
  output glcc_pkg::op_entry_t                      entry
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int DW    = glcc_pkg::COORD_W + 1;

  logic signed [DW-1:0]         diff_x;
  logic signed [DW-1:0]         diff_y;
  logic [glcc_pkg::CNT_W-1:0]   dx;
  logic [glcc_pkg::CNT_W-1:0]   dy;

  // Hold off new commands while the queue is full or the map is clearing
  assign busy = q_stat.full | clearing;
  assign push = start & ~busy;

  // Signed spans and their magnitudes
  assign diff_x = DW'(end_x) - DW'(start_x);
  assign diff_y = DW'(end_y) - DW'(start_y);
  assign dx     = diff_x[DW-1] ? glcc_pkg::CNT_W'(-diff_x) : glcc_pkg::CNT_W'(diff_x);
  assign dy     = diff_y[DW-1] ? glcc_pkg::CNT_W'(-diff_y) : glcc_pkg::CNT_W'(diff_y);

  // Build the queue entry
  always_comb begin
    entry.is_query   = (opcode == glcc_pkg::OP_QUERY);
    entry.cell_index = cell_index;
    entry.in_range   = ({16'd0, cell_index} < 32'(DEPTH));
    entry.cell_busy  = (cell_value != 8'sd0);
    entry.x1         = start_x;
    entry.y1         = start_y;
    entry.xs_neg     = diff_x[DW-1] | (diff_x == '0);
    entry.ys_neg     = diff_y[DW-1] | (diff_y == '0);
    entry.dx2        = {dx, 1'b0};
    entry.dy2        = {dy, 1'b0};
    entry.err        = glcc_pkg::ERR_W'(dx) - glcc_pkg::ERR_W'(dy);
    entry.n          = glcc_pkg::CNT_W'(12'd1 + 12'(dx) + 12'(dy));
  end

endmodule

`default_nettype wire

FILE: hdl/glcc_queue.sv
// Short command queue between the front and back ends.
// Uses glcc_pkg for the entry type, status struct and depth.
`default_nettype none

module glcc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire glcc_pkg::op_entry_t entry_in,
  input  wire logic                pop,
  output glcc_pkg::op_entry_t      entry_out,
  output glcc_pkg::q_status_t      q_stat
);

  localparam int PTR_W = (glcc_pkg::QUEUE_DEPTH > 1) ? $clog2(glcc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(glcc_pkg::QUEUE_DEPTH + 1);

  glcc_pkg::op_entry_t slots [glcc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign entry_out    = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(glcc_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(glcc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(glcc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/glcc_back.sv
// Back end: clears the map after reset, executes cell writes and walks query lines.
// Uses glcc_pkg and instantiates glcc_ram for the occupancy map.
`default_nettype none

module glcc_back #(
  parameter int MAX_SIDE = glcc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire glcc_pkg::dims_t                     dims,
  input  wire glcc_pkg::op_entry_t                 head,
  input  wire glcc_pkg::q_status_t                 q_stat,
  output logic                                     pop,
  output logic                                     clearing,
  output logic                                     done,
  output logic             [glcc_pkg::STAT_W-1:0]  status,
  output logic signed      [glcc_pkg::COORD_W-1:0] stop_x,
  output logic signed      [glcc_pkg::COORD_W-1:0] stop_y,
  output logic             [glcc_pkg::CNT_W-1:0]   cells_checked
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIN_W  = 2 * glcc_pkg::DIM_W + 1;
  localparam int CW     = glcc_pkg::COORD_W;

  // Clearing sweep
  logic [ADDR_W-1:0] clr_addr;

  // Walk stage: current cell
  logic                        walk_act;
  logic signed [CW-1:0]        wx;
  logic signed [CW-1:0]        wy;
  logic signed [glcc_pkg::ERR_W-1:0] werr;
  logic [glcc_pkg::ERR_W-1:0]  wdx2;
  logic [glcc_pkg::ERR_W-1:0]  wdy2;
  logic                        wxs_neg;
  logic                        wys_neg;
  logic [glcc_pkg::CNT_W-1:0]  wrem;
  logic [glcc_pkg::CNT_W-1:0]  wcnt;

  // Check stage: cell whose map bit is arriving
  logic                        chk_act;
  logic signed [CW-1:0]        bx;
  logic signed [CW-1:0]        by;
  logic [glcc_pkg::CNT_W-1:0]  bcnt;
  logic                        boob;
  logic                        blast;

  // Map port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  logic              oob_a;
  logic [LIN_W-1:0]  lin_a;
  logic              stop_b;
  glcc_pkg::status_t stat_b;

  // Take the next command only when the walk pipe is empty
  assign pop = ~q_stat.empty & ~clearing & ~walk_act & ~chk_act;

  // Bounds and linear address of the current walk cell
  assign oob_a = wx[CW-1] | (wx[glcc_pkg::DIM_W-1:0] >= dims.width) |
                 wy[CW-1] | (wy[glcc_pkg::DIM_W-1:0] >= dims.height);
  assign lin_a = LIN_W'(wy[glcc_pkg::DIM_W-1:0]) * LIN_W'(dims.width) +
                 LIN_W'(wx[glcc_pkg::DIM_W-1:0]);
  assign ram_raddr = ADDR_W'(lin_a);

  // Write port: clearing sweep or a queued cell write
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = pop & ~head.is_query & head.in_range;
      ram_waddr = ADDR_W'(head.cell_index);
      ram_wdata = head.cell_busy;
    end
  end

  // Decide on the checked cell
  always_comb begin
    stop_b = chk_act & (boob | ram_rdata | blast);
    priority if (boob) begin
      stat_b = glcc_pkg::ST_OOB;
    end else if (ram_rdata) begin
      stat_b = glcc_pkg::ST_HIT;
    end else begin
      stat_b = glcc_pkg::ST_FREE;
    end
  end

  glcc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control: clearing sweep, walk and check valid, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      walk_act <= 1'b0;
      chk_act  <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      done <= stop_b;
      if (stop_b) begin
        walk_act <= 1'b0;
        chk_act  <= 1'b0;
      end else begin
        chk_act <= walk_act;
        if (pop && head.is_query) begin
          walk_act <= 1'b1;
        end else if (walk_act && wrem == glcc_pkg::CNT_W'(1)) begin
          walk_act <= 1'b0;
        end
      end
    end
  end

  // Walk datapath: load on a query, step one cell a cycle
  always_ff @(posedge clk) begin
    if (pop && head.is_query) begin
      wx      <= head.x1;
      wy      <= head.y1;
      werr    <= head.err;
      wdx2    <= head.dx2;
      wdy2    <= head.dy2;
      wxs_neg <= head.xs_neg;
      wys_neg <= head.ys_neg;
      wrem    <= head.n;
      wcnt    <= glcc_pkg::CNT_W'(1);
    end else if (walk_act) begin
      wrem <= wrem - 1'b1;
      wcnt <= wcnt + 1'b1;
      if (werr > 12'sd0) begin
        wx   <= wxs_neg ? wx - 10'sd1 : wx + 10'sd1;
        werr <= werr - $signed(wdy2);
      end else begin
        wy   <= wys_neg ? wy - 10'sd1 : wy + 10'sd1;
        werr <= werr + $signed(wdx2);
      end
    end
  end

  // Check stage payload: registered in step with the map read data
  always_ff @(posedge clk) begin
    bx    <= wx;
    by    <= wy;
    bcnt  <= wcnt;
    boob  <= oob_a;
    blast <= (wrem == glcc_pkg::CNT_W'(1));
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (stop_b) begin
      status        <= stat_b;
      stop_x        <= bx;
      stop_y        <= by;
      cells_checked <= bcnt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/grid_line_collision_check.sv
// Top level of the grid line collision checker: configuration registers and
// the front end, command queue and back end. Uses glcc_pkg, glcc_front,
// glcc_queue and glcc_back.
//
// A command is taken on a rising edge with start high and busy low. A cell write
// (opcode 0) gives no result. A line query (opcode 1) steps the line one cell
// per clock through the occupancy map read port, and its result shows on done
// for one cycle once the walk stops. The result cannot be held off: it must be
// taken in the cycle done is high. A two-entry queue takes new commands while a
// walk is in progress. After reset the map is cleared, one cell per cycle, over
// all MAX_SIDE*MAX_SIDE cells (65536 at the default), with busy held high;
// register writes are taken during that sweep. Width and height above MAX_SIDE
// act as MAX_SIDE.
`default_nettype none

module grid_line_collision_check #(
  parameter int MAX_SIDE = glcc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Command transfer
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 opcode,
  input  wire logic        [glcc_pkg::IDX_W-1:0]    cell_index,
  input  wire logic signed [glcc_pkg::VAL_W-1:0]    cell_value,
  input  wire logic signed [glcc_pkg::COORD_W-1:0]  start_x,
  input  wire logic signed [glcc_pkg::COORD_W-1:0]  start_y,
  input  wire logic signed [glcc_pkg::COORD_W-1:0]  end_x,
  input  wire logic signed [glcc_pkg::COORD_W-1:0]  end_y,
  // Result transfer
  output logic                                      done,
  output logic             [glcc_pkg::STAT_W-1:0]   status,
  output logic signed      [glcc_pkg::COORD_W-1:0]  stop_x,
  output logic signed      [glcc_pkg::COORD_W-1:0]  stop_y,
  output logic             [glcc_pkg::CNT_W-1:0]    cells_checked,
  // Configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic        [glcc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [glcc_pkg::DATA_W-1:0]   pwdata,
  output logic             [glcc_pkg::DATA_W-1:0]   prdata,
  output logic                                      pready
);

  localparam int DW = glcc_pkg::DIM_W;

  logic [DW-1:0]       map_width;
  logic [DW-1:0]       map_height;
  logic                cfg_we;
  glcc_pkg::dims_t     dims;
  glcc_pkg::q_status_t q_stat;
  glcc_pkg::op_entry_t push_entry;
  glcc_pkg::op_entry_t head;
  logic                push;
  logic                pop;
  logic                clearing;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DW'(256);
      map_height <= DW'(256);
    end else if (cfg_we) begin
      unique case (paddr[2])
        glcc_pkg::REG_WIDTH:  map_width  <= pwdata[DW-1:0];
        glcc_pkg::REG_HEIGHT: map_height <= pwdata[DW-1:0];
        default:              map_width  <= map_width;
      endcase
    end
  end

  assign prdata = (paddr[2] == glcc_pkg::REG_HEIGHT) ?
                  glcc_pkg::DATA_W'(map_height) : glcc_pkg::DATA_W'(map_width);

  // Clamp dimensions to the map side
  assign dims.width  = (32'(map_width)  > 32'(MAX_SIDE)) ? DW'(MAX_SIDE) : map_width;
  assign dims.height = (32'(map_height) > 32'(MAX_SIDE)) ? DW'(MAX_SIDE) : map_height;

  glcc_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .q_stat     (q_stat),
    .clearing   (clearing),
    .push       (push),
    .entry      (push_entry)
  );

  glcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (pop),
    .entry_out (head),
    .q_stat    (q_stat)
  );

  glcc_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .clearing      (clearing),
    .done          (done),
    .status        (status),
    .stop_x        (stop_x),
    .stop_y        (stop_y),
    .cells_checked (cells_checked)
  );

endmodule

`default_nettype wire

FILE: hdl/glcc_checker.sv
// Port-level checker for the grid line collision checker, bound to the top level.
// Uses only the top-level ports; no package needed.
`default_nettype none

module glcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [10:0] cells_checked,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // Map clearing holds off commands right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("busy low in the cycle after reset");

  // A result always covers at least one cell
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> cells_checked != 11'd0)
    else $error("result with zero cells checked");

  // Results are never back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // A width write reads back on the next cycle
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata == {23'd0, $past(pwdata[8:0])})
    else $error("width register readback mismatch");

endmodule

bind grid_line_collision_check glcc_checker u_glcc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .cells_checked (cells_checked),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire

FILE: tb/sv/grid_line_collision_check_test.sv
// Self-checking testbench for grid_line_collision_check: cell writes and line
// queries against a behavioral line walker with its own occupancy map.
// Depends on glcc_pkg and the grid_line_collision_check RTL only.

module grid_line_collision_check_test;
  import glcc_pkg::*;

  localparam int SIDE          = MAX_SIDE_DEF;
  localparam int DEPTH         = SIDE * SIDE;
  localparam int IDLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SHOW_LIMIT    = 30;
  localparam int PHASE_ITEMS   = 175;
  localparam int PHASES        = 8;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic signed [VAL_W-1:0]   val;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } grid_cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [COORD_W-1:0] stop_x;
    logic signed [COORD_W-1:0] stop_y;
    logic [CNT_W-1:0]          count;
  } walk_result_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      opcode;
  logic [IDX_W-1:0]          cell_index;
  logic signed [VAL_W-1:0]   cell_value;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic                      done;
  logic [STAT_W-1:0]         status;
  logic signed [COORD_W-1:0] stop_x;
  logic signed [COORD_W-1:0] stop_y;
  logic [CNT_W-1:0]          cells_checked;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // Walker state: occupancy bits and the programmed dimensions
  bit               occ_map [0:DEPTH-1];
  logic [DIM_W-1:0] grid_w;
  logic [DIM_W-1:0] grid_h;
  walk_result_t     pending_walks [$];

  // Window of the map that random traffic concentrates on
  int win_x0, win_y0, span_x, span_y;

  int errors, idle_cycles;
  int n_writes, n_queries, n_settings;
  int n_free, n_oob, n_hit;

  grid_line_collision_check dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .cell_index    (cell_index),
    .cell_value    (cell_value),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .done          (done),
    .status        (status),
    .stop_x        (stop_x),
    .stop_y        (stop_y),
    .cells_checked (cells_checked),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= SHOW_LIMIT) $display("MISMATCH: %s", what);
  endtask

  function automatic int eff_side(input logic [DIM_W-1:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  // Walk the 4-connected line with a doubled error term, stop at the first
  // cell that is off the map or occupied
  function automatic walk_result_t trace_line(input logic signed [COORD_W-1:0] ax,
                                              input logic signed [COORD_W-1:0] ay,
                                              input logic signed [COORD_W-1:0] bx,
                                              input logic signed [COORD_W-1:0] by);
    int x, y, tx, ty, w, h, dx, dy, n, xs, ys, err, lx, ly, cnt;
    status_t st;
    walk_result_t r;
    x   = ax;
    y   = ay;
    tx  = bx;
    ty  = by;
    w   = eff_side(grid_w);
    h   = eff_side(grid_h);
    dx  = (tx > x) ? tx - x : x - tx;
    dy  = (ty > y) ? ty - y : y - ty;
    n   = 1 + dx + dy;
    xs  = (tx > x) ? 1 : -1;
    ys  = (ty > y) ? 1 : -1;
    err = dx - dy;
    dx  = 2 * dx;
    dy  = 2 * dy;
    lx  = x;
    ly  = y;
    cnt = 0;
    st  = ST_FREE;
    while (n > 0) begin
      lx = x;
      ly = y;
      cnt++;
      if (x < 0 || x >= w || y < 0 || y >= h) begin
        st = ST_OOB;
        break;
      end
      if (occ_map[x + y * w]) begin
        st = ST_HIT;
        break;
      end
      if (err > 0) begin
        x   += xs;
        err -= dy;
      end else begin
        y   += ys;
        err += dx;
      end
      n--;
    end
    r.status = st;
    r.stop_x = lx[COORD_W-1:0];
    r.stop_y = ly[COORD_W-1:0];
    r.count  = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic grid_cmd_t make_write(input int idx, input int val);
    grid_cmd_t c;
    c.op  = OP_WRITE;
    c.idx = idx[IDX_W-1:0];
    c.val = val[VAL_W-1:0];
    c.x1  = COORD_W'($urandom());
    c.y1  = COORD_W'($urandom());
    c.x2  = COORD_W'($urandom());
    c.y2  = COORD_W'($urandom());
    return c;
  endfunction

  function automatic grid_cmd_t make_query(input int x1, input int y1,
                                           input int x2, input int y2);
    grid_cmd_t c;
    c.op  = OP_QUERY;
    c.idx = IDX_W'($urandom());
    c.val = VAL_W'($urandom());
    c.x1  = x1[COORD_W-1:0];
    c.y1  = y1[COORD_W-1:0];
    c.x2  = x2[COORD_W-1:0];
    c.y2  = y2[COORD_W-1:0];
    return c;
  endfunction

  // Drive one command and hold it until the transfer; record its effect
  task automatic send_item(input grid_cmd_t c);
    opcode     = c.op;
    cell_index = c.idx;
    cell_value = c.val;
    start_x    = c.x1;
    start_y    = c.y1;
    end_x      = c.x2;
    end_y      = c.y2;
    start      = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (c.op == OP_WRITE) begin
      occ_map[c.idx] = (c.val != 0);
      n_writes++;
    end else begin
      pending_walks.insert(pending_walks.size(), trace_line(c.x1, c.y1, c.x2, c.y2));
      n_queries++;
    end
    @(negedge clk);
  endtask

  // Hold off new commands until every query has answered
  task automatic wait_for_results();
    start = 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain, then let trailing cell writes retire before touching registers
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic sel, input int val);
    logic [DATA_W-1:0] data;
    data    = ($urandom() & ~32'h1FF) | (val & 32'h1FF);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (sel == REG_WIDTH) grid_w = data[DIM_W-1:0];
    else grid_h = data[DIM_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(input logic sel);
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] got;
    want    = {{(DATA_W-DIM_W){1'b0}}, (sel == REG_WIDTH) ? grid_w : grid_h};
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {sel, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register %0d read %0h, want %0h", sel, got, want));
  endtask

  task automatic set_dims(input int w, input int h);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_check(REG_WIDTH);
    apb_check(REG_HEIGHT);
    n_settings++;
  endtask

  function automatic int local_x();
    return win_x0 + int'($urandom_range(0, span_x + 3)) - 2;
  endfunction

  function automatic int local_y();
    return win_y0 + int'($urandom_range(0, span_y + 3)) - 2;
  endfunction

  // Mostly short lines and writes inside the window, plus long lines and noise
  function automatic grid_cmd_t random_cmd();
    int ew, eh, x1, y1, x2, y2, roll, val;
    ew   = eff_side(grid_w);
    eh   = eff_side(grid_h);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      val = ($urandom_range(0, 99) < 45) ? 0 : int'($urandom_range(1, 255));
      if ($urandom_range(0, 99) < 75 && ew > 0 && eh > 0) begin
        x1 = win_x0 + int'($urandom_range(0, span_x - 1));
        y1 = win_y0 + int'($urandom_range(0, span_y - 1));
        return make_write(x1 + y1 * ew, val);
      end
      return make_write(int'($urandom_range(0, 65535)), val);
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      x1 = local_x();
      y1 = local_y();
      x2 = x1 + int'($urandom_range(0, 12)) - 6;
      y2 = y1 + int'($urandom_range(0, 12)) - 6;
    end else if (roll < 80 && ew > 0 && eh > 0) begin
      x1 = $urandom_range(0, ew - 1);
      y1 = $urandom_range(0, eh - 1);
      x2 = $urandom_range(0, ew - 1);
      y2 = $urandom_range(0, eh - 1);
    end else begin
      x1 = int'($urandom_range(0, 1023)) - 512;
      y1 = int'($urandom_range(0, 1023)) - 512;
      x2 = int'($urandom_range(0, 1023)) - 512;
      y2 = int'($urandom_range(0, 1023)) - 512;
    end
    return make_query(x1, y1, x2, y2);
  endfunction

  // Reset dimensions, cleared map, bounds at the default side
  task automatic test_reset_defaults();
    send_item(make_query(255, 255, 255, 255));
    send_item(make_query(250, 0, 256, 0));
    send_item(make_query(-512, -512, 511, 511));
    settle();
  endtask

  // Writes at index and value extremes, set and clear
  task automatic test_cell_writes();
    send_item(make_write(65535, -128));
    send_item(make_query(255, 253, 255, 255));
    send_item(make_write(0, 127));
    send_item(make_write(1, 0));
    send_item(make_query(0, 0, 3, 0));
    send_item(make_write(0, 0));
    send_item(make_query(0, 0, 3, 0));
    send_item(make_write(257, 1));
    send_item(make_query(0, 0, 2, 2));
    settle();
  endtask

  // Directions, a long free diagonal, a start off the map, leaving the map at negative y
  task automatic test_line_shapes();
    send_item(make_query(10, 20, 3, 5));
    send_item(make_query(0, 255, 255, 0));
    send_item(make_query(511, -512, -512, 511));
    send_item(make_query(5, 5, 5, -3));
    send_item(make_write(65535, 0));
    settle();
  endtask

  // Zero, minimal and oversized dimensions
  task automatic test_dimension_edges();
    set_dims(0, 256);
    send_item(make_query(0, 0, 1, 1));
    settle();
    set_dims(256, 0);
    send_item(make_query(3, 0, 1, 0));
    settle();
    set_dims(1, 1);
    send_item(make_query(0, 0, 0, 0));
    send_item(make_query(0, 0, 1, 0));
    settle();
    set_dims(511, 511);
    send_item(make_query(255, 255, 257, 255));
    settle();
    set_dims(257, 300);
    send_item(make_query(250, 250, 260, 256));
    settle();
  endtask

  // Random bursts over several map settings
  task automatic test_random_traffic();
    int p, left, burst, gap, ew, eh;
    bit paused;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_dims(16, 16);
        1:       set_dims(256, 256);
        2:       set_dims(1, 256);
        3:       set_dims(37, 100);
        4:       set_dims(0, $urandom_range(1, 511));
        5:       set_dims(511, 300);
        6:       set_dims(200, 1);
        default: set_dims($urandom_range(1, 511), $urandom_range(1, 511));
      endcase
      ew     = eff_side(grid_w);
      eh     = eff_side(grid_h);
      span_x = (ew == 0) ? 4 : ((ew < 20) ? ew : 20);
      span_y = (eh == 0) ? 4 : ((eh < 20) ? eh : 20);
      win_x0 = (ew > span_x) ? (($urandom_range(0, 1) == 1) ? ew - span_x :
                                int'($urandom_range(0, ew - span_x))) : 0;
      win_y0 = (eh > span_y) ? (($urandom_range(0, 1) == 1) ? eh - span_y :
                                int'($urandom_range(0, eh - span_y))) : 0;
      left   = PHASE_ITEMS;
      paused = 1'b0;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) begin
          send_item(random_cmd());
          left--;
        end
        // Pause once per phase until the queue has fully answered
        if (!paused && left <= PHASE_ITEMS / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        gap = (p % 3 == 0) ? 0 : int'($urandom_range(0, 12));
        if (gap > 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      settle();
    end
  endtask

  // Compare each result with the oldest predicted walk
  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (!rst && done === 1'b1) begin
      case (status)
        ST_FREE: n_free++;
        ST_OOB:  n_oob++;
        ST_HIT:  n_hit++;
        default: ;
      endcase
      if (pending_walks.size() == 0) begin
        report_mismatch($sformatf("result with no query waiting: status %0d at (%0d,%0d)",
                                  status, stop_x, stop_y));
      end else begin
        want = pending_walks.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (stop_x !== want.stop_x)
          report_mismatch($sformatf("stop_x %0d, want %0d", stop_x, want.stop_x));
        if (stop_y !== want.stop_y)
          report_mismatch($sformatf("stop_y %0d, want %0d", stop_y, want.stop_y));
        if (cells_checked !== want.count)
          report_mismatch($sformatf("cells_checked %0d, want %0d",
                                    cells_checked, want.count));
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d queries outstanding",
               IDLE_LIMIT, pending_walks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    opcode      = OP_WRITE;
    cell_index  = '0;
    cell_value  = '0;
    start_x     = '0;
    start_y     = '0;
    end_x       = '0;
    end_y       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    grid_w      = 9'd256;
    grid_h      = 9'd256;
    errors      = 0;
    idle_cycles = 0;
    n_writes    = 0;
    n_queries   = 0;
    n_settings  = 0;
    n_free      = 0;
    n_oob       = 0;
    n_hit       = 0;
    foreach (occ_map[i]) occ_map[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_cell_writes();
    test_line_shapes();
    test_dimension_edges();
    test_random_traffic();

    settle();
    if (pending_walks.size() != 0)
      report_mismatch($sformatf("%0d queries never answered", pending_walks.size()));
    $display("Ran %0d cell writes and %0d line queries over %0d register settings",
             n_writes, n_queries, n_settings);
    $display("Walks ended free %0d, off map %0d, blocked %0d; mismatches %0d",
             n_free, n_oob, n_hit, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
